@@ design/thc_pkg.sv @@
// ----------------------------------------------------------------------------
// Thermistor conversion package
// Shared widths, register indexes, status codes and constants.
// ----------------------------------------------------------------------------
`default_nettype none

package thc_pkg;

  // Default values for the top-level parameters.
  localparam int ADC_BITS_DEF       = 16;
  localparam int TEMP_FRAC_BITS_DEF = 8;

  // Field and register widths.
  localparam int ADC_W      = 16;
  localparam int TEMP_W     = 24;
  localparam int STATUS_W   = 2;
  localparam int PULLUP_W   = 20;
  localparam int INLINE_W   = 17;
  localparam int COEF_W     = 48;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int REG_IDX_W  = 3;

  // Register indexes, taken from paddr[5:3].
  localparam logic [REG_IDX_W-1:0] REG_PULLUP = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_INLINE = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COEF_A = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COEF_B = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COEF_C = 3'd4;

  // Reset value of the pull-up register.
  localparam logic [PULLUP_W-1:0] PULLUP_RESET = 20'd4700;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RES = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INV = 2'd2;

  // Logarithm constants: fraction bits and ln(2) in Q28.
  localparam int          LOG_FRAC_BITS = 30;
  localparam logic [27:0] LN2_Q28       = 28'd186065279;

  // Largest output temperature.
  localparam int TEMP_MAX = 8388607;

endpackage

`default_nettype wire

@@ design/thc_ifs.sv @@
// ----------------------------------------------------------------------------
// Thermistor conversion channels
// Valid/ready channels for ADC readings in and temperatures out.
// ----------------------------------------------------------------------------
`default_nettype none

// Channel that carries one ADC reading per item.
interface thc_in_if;
  logic                     valid;
  logic                     ready;
  logic [thc_pkg::ADC_W-1:0] adc_fraction;

  modport source (output valid, output adc_fraction, input ready);
  modport sink   (input valid, input adc_fraction, output ready);
endinterface

// Channel that carries one temperature result per item.
interface thc_out_if;
  logic                         valid;
  logic                         ready;
  logic signed [thc_pkg::TEMP_W-1:0] temp_q8;
  logic [thc_pkg::STATUS_W-1:0] status;

  modport source (output valid, output temp_q8, output status, input ready);
  modport sink   (input valid, input temp_q8, input status, output ready);
endinterface

`default_nettype wire

@@ design/thermistor_adc_to_temperature_unit.sv @@
// ----------------------------------------------------------------------------
// Thermistor ADC to temperature unit
// Converts ADC readings of a pull-up divider into temperature with the
// Steinhart-Hart equation in fixed point.
// ----------------------------------------------------------------------------
// Usage: each item on the sample channel is one ADC reading; each item on the
// result channel is a temperature in 1/2^TEMP_FRAC_BITS degree Celsius and a
// status code. Every reading gives exactly one result, in order.
// The pipeline takes one item per cycle while the receiver does not stall.
// Its stages include the two restoring dividers (52 stages for resistance
// and NUM2 stages for the reciprocal, where NUM2 = max(40 + TEMP_FRAC_BITS,
// 49) + 1) and the 30 squaring stages of the logarithm.
// Configuration is written through the APB port while the block is idle:
// 8-byte registers pullup, inline, coef_a, coef_b, coef_cubic from address 0.
// Reset clears the pipeline valid bits and loads the register reset values.
// When the receiver stalls, the whole pipeline holds and sample.ready drops;
// nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module thermistor_adc_to_temperature_unit #(
  parameter int ADC_BITS       = thc_pkg::ADC_BITS_DEF,
  parameter int TEMP_FRAC_BITS = thc_pkg::TEMP_FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  thc_in_if.sink                                 sample,
  thc_out_if.source                              result,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [thc_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [thc_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic      [thc_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                   pready
);

  localparam int AW    = thc_pkg::ADC_W;
  localparam int CW    = (ADC_BITS + 1 > AW) ? ADC_BITS + 1 : AW;
  localparam int NUM1  = thc_pkg::PULLUP_W + AW + 16;
  localparam int SQ_N  = thc_pkg::LOG_FRAC_BITS;
  localparam int NUM2  = ((40 + TEMP_FRAC_BITS > 49) ? 40 + TEMP_FRAC_BITS : 49) + 1;
  localparam int DEN2  = 50;
  localparam int INV_W = 51;
  localparam int TW    = 50;
  localparam int KEL   = ((27315 << TEMP_FRAC_BITS) + 50) / 100;
  localparam logic [CW-1:0]   FULL    = CW'(1) << ADC_BITS;
  localparam logic [CW-1:0]   LIM     = FULL - CW'(1);
  localparam logic [NUM2-1:0] SAT_LIM = NUM2'(KEL + thc_pkg::TEMP_MAX);
  localparam logic [NUM2-1:0] KEL_N   = NUM2'(KEL);
  localparam logic [NUM2-1:0] ONE_N   = NUM2'(1) << (40 + TEMP_FRAC_BITS);

  // Configuration registers.
  logic        [thc_pkg::PULLUP_W-1:0] pullup_ohms;
  logic        [thc_pkg::INLINE_W-1:0] inline_ohms;
  logic signed [thc_pkg::COEF_W-1:0]   coef_a;
  logic signed [thc_pkg::COEF_W-1:0]   coef_b;
  logic signed [thc_pkg::COEF_W-1:0]   coef_cubic;
  logic        [thc_pkg::REG_IDX_W-1:0] reg_idx;
  logic        [thc_pkg::COEF_W-1:0]   coef_b_mag;
  logic        [thc_pkg::COEF_W-1:0]   coef_c_mag;

  assign pready  = 1'b1;
  assign reg_idx = paddr[thc_pkg::CFG_ADDR_W-1:3];

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      pullup_ohms <= thc_pkg::PULLUP_RESET;
      inline_ohms <= '0;
      coef_a      <= '0;
      coef_b      <= '0;
      coef_cubic  <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        thc_pkg::REG_PULLUP: pullup_ohms <= pwdata[thc_pkg::PULLUP_W-1:0];
        thc_pkg::REG_INLINE: inline_ohms <= pwdata[thc_pkg::INLINE_W-1:0];
        thc_pkg::REG_COEF_A: coef_a      <= pwdata[thc_pkg::COEF_W-1:0];
        thc_pkg::REG_COEF_B: coef_b      <= pwdata[thc_pkg::COEF_W-1:0];
        thc_pkg::REG_COEF_C: coef_cubic  <= pwdata[thc_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      thc_pkg::REG_PULLUP: prdata = thc_pkg::CFG_DATA_W'(pullup_ohms);
      thc_pkg::REG_INLINE: prdata = thc_pkg::CFG_DATA_W'(inline_ohms);
      thc_pkg::REG_COEF_A: prdata = thc_pkg::CFG_DATA_W'(coef_a);
      thc_pkg::REG_COEF_B: prdata = thc_pkg::CFG_DATA_W'(coef_b);
      thc_pkg::REG_COEF_C: prdata = thc_pkg::CFG_DATA_W'(coef_cubic);
      default:             prdata = '0;
    endcase
  end

  // Coefficient magnitudes for the unsigned multipliers.
  assign coef_b_mag = coef_b[thc_pkg::COEF_W-1] ? (-coef_b) : coef_b;
  assign coef_c_mag = coef_cubic[thc_pkg::COEF_W-1] ? (-coef_cubic) : coef_cubic;

  // Global advance: the pipeline moves unless a result waits at the output.
  // No item is taken while reset is held.
  logic advance;
  logic out_valid;
  assign advance      = !out_valid || result.ready;
  assign sample.ready = advance && !rst;

  // Reading clamp and divisor.
  logic [AW-1:0] a_clamp;
  always_comb begin
    a_clamp = (sample.adc_fraction == '0) ? AW'(1) : sample.adc_fraction;
    if (CW'(a_clamp) > LIM) begin
      a_clamp = AW'(LIM);
    end
  end

  logic                          v0, v1;
  logic [AW-1:0]                 a0;
  logic [ADC_BITS-1:0]           d0, d1;
  logic [thc_pkg::PULLUP_W+AW-1:0] n1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (advance) begin
      v0 <= sample.valid;
      v1 <= v0;
    end
  end

  // Input register, then pull-up times reading.
  always_ff @(posedge clk) begin
    if (advance) begin
      a0 <= a_clamp;
      d0 <= ADC_BITS'(FULL - CW'(a_clamp));
      n1 <= pullup_ohms * a0;
      d1 <= d0;
    end
  end

  // Resistance in Q16 ohms.
  logic [NUM1-1:0] r_q;
  logic            r_v;

  thc_div #(.NW(NUM1), .DW(ADC_BITS), .SW(1)) u_div_res (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .num      ({n1, 16'b0}),
    .den      (d1),
    .side_in  (v1),
    .quo      (r_q),
    .side_out (r_v)
  );

  // Subtract the inline resistor and flag a non-positive resistance.
  logic                         v2;
  logic [NUM1-1:0]              x2;
  logic [thc_pkg::STATUS_W-1:0] st2;
  logic [NUM1-1:0]              inl;
  assign inl = NUM1'({inline_ohms, 16'b0});

  // Leading-one normalization, two shift steps per stage.
  logic                         nv1, nv2, nv3;
  logic [63:0]                  nw1, nw2, nw3;
  logic [5:0]                   nz1, nz2, nz3;
  logic [thc_pkg::STATUS_W-1:0] ns1, ns2, ns3;
  logic [63:0]                  nw1_next, nw2_next, nw3_next;
  logic [5:0]                   nz1_next, nz2_next, nz3_next;

  always_comb begin
    nw1_next = 64'(x2);
    nz1_next = '0;
    if (nw1_next[63:32] == '0) begin
      nw1_next = nw1_next << 32;
      nz1_next = nz1_next + 6'd32;
    end
    if (nw1_next[63:48] == '0) begin
      nw1_next = nw1_next << 16;
      nz1_next = nz1_next + 6'd16;
    end
  end

  always_comb begin
    nw2_next = nw1;
    nz2_next = nz1;
    if (nw2_next[63:56] == '0) begin
      nw2_next = nw2_next << 8;
      nz2_next = nz2_next + 6'd8;
    end
    if (nw2_next[63:60] == '0) begin
      nw2_next = nw2_next << 4;
      nz2_next = nz2_next + 6'd4;
    end
  end

  always_comb begin
    nw3_next = nw2;
    nz3_next = nz2;
    if (nw3_next[63:62] == '0) begin
      nw3_next = nw3_next << 2;
      nz3_next = nz3_next + 6'd2;
    end
    if (!nw3_next[63]) begin
      nw3_next = nw3_next << 1;
      nz3_next = nz3_next + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2  <= 1'b0;
      nv1 <= 1'b0;
      nv2 <= 1'b0;
      nv3 <= 1'b0;
    end else if (advance) begin
      v2  <= r_v;
      nv1 <= v2;
      nv2 <= nv1;
      nv3 <= nv2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      x2  <= r_q - inl;
      st2 <= (r_q <= inl) ? thc_pkg::ST_RES : thc_pkg::ST_OK;
      nw1 <= nw1_next;
      nz1 <= nz1_next;
      ns1 <= st2;
      nw2 <= nw2_next;
      nz2 <= nz2_next;
      ns2 <= ns1;
      nw3 <= nw3_next;
      nz3 <= nz3_next;
      ns3 <= ns2;
    end
  end

  // Fraction bits of log2 by repeated squaring of the Q1.31 mantissa.
  logic [31:0]                  sq_m [SQ_N];
  logic [SQ_N-1:0]              sq_f [SQ_N];
  logic [5:0]                   sq_e [SQ_N];
  logic [thc_pkg::STATUS_W-1:0] sq_s [SQ_N];
  logic                         sq_v [SQ_N];

  for (genvar i = 0; i < SQ_N; i++) begin : g_sq
    logic [31:0]                  cur_m;
    logic [SQ_N-1:0]              cur_f;
    logic [5:0]                   cur_e;
    logic [thc_pkg::STATUS_W-1:0] cur_s;
    logic                         cur_v;
    logic [63:0]                  prod;
    logic [32:0]                  sqr;

    if (i == 0) begin : g_first
      assign cur_m = nw3[63:32];
      assign cur_f = '0;
      assign cur_e = 6'd63 - nz3;
      assign cur_s = ns3;
      assign cur_v = nv3;
    end else begin : g_next
      assign cur_m = sq_m[i-1];
      assign cur_f = sq_f[i-1];
      assign cur_e = sq_e[i-1];
      assign cur_s = sq_s[i-1];
      assign cur_v = sq_v[i-1];
    end

    assign prod = cur_m * cur_m;
    assign sqr  = prod[63:31];

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[i] <= 1'b0;
      end else if (advance) begin
        sq_v[i] <= cur_v;
      end
    end

    // A square at or above two yields a one bit and a halving.
    always_ff @(posedge clk) begin
      if (advance) begin
        if (sqr[32]) begin
          sq_m[i] <= sqr[32:1];
        end else begin
          sq_m[i] <= sqr[31:0];
        end
        sq_f[i] <= {cur_f[SQ_N-2:0], sqr[32]};
        sq_e[i] <= cur_e;
        sq_s[i] <= cur_s;
      end
    end
  end

  // Signed log2 in Q30, split into magnitude and sign.
  logic signed [6:0]            l_exp;
  logic signed [36:0]           l_two;
  logic                         lv;
  logic [35:0]                  l_mag;
  logic                         l_neg;
  logic [thc_pkg::STATUS_W-1:0] l_st;

  assign l_exp = $signed({1'b0, sq_e[SQ_N-1]}) - 7'sd16;
  assign l_two = {l_exp, sq_f[SQ_N-1]};

  // Sideband stages around the multipliers.
  logic                         m1_v, m2_v, q1_v, q2_v, r1_v, r2_v, c1_v, c2_v;
  logic                         m1_n, m2_n, q1_n, q2_n, r1_n, r2_n, c1_n, c2_n;
  logic [thc_pkg::STATUS_W-1:0] m1_s, m2_s, q1_s, q2_s, r1_s, r2_s, c1_s, c2_s;
  logic [34:0]                  q1_l, q2_l, r1_l, r2_l;

  logic [63:0] p_ln;
  logic [69:0] p_sq;
  logic [74:0] p_cu;
  logic [82:0] p_b;
  logic [92:0] p_c;
  logic [34:0] ln_mag;
  logic [39:0] ln_sq;
  logic [44:0] ln_cu;

  assign ln_mag = p_ln[62:28];
  assign ln_sq  = p_sq[69:30];
  assign ln_cu  = p_cu[74:30];

  // Natural log: log2 times ln(2).
  thc_mul #(.AW(36), .BW(28)) u_mul_ln (
    .clk (clk), .en (advance), .a (l_mag), .b (thc_pkg::LN2_Q28), .p (p_ln)
  );

  // Square of the log.
  thc_mul #(.AW(35), .BW(35)) u_mul_sq (
    .clk (clk), .en (advance), .a (ln_mag), .b (ln_mag), .p (p_sq)
  );

  // Cube of the log.
  thc_mul #(.AW(40), .BW(35)) u_mul_cu (
    .clk (clk), .en (advance), .a (ln_sq), .b (q2_l), .p (p_cu)
  );

  // Linear and cubic coefficient products.
  thc_mul #(.AW(thc_pkg::COEF_W), .BW(35)) u_mul_b (
    .clk (clk), .en (advance), .a (coef_b_mag), .b (r2_l), .p (p_b)
  );

  thc_mul #(.AW(thc_pkg::COEF_W), .BW(45)) u_mul_c (
    .clk (clk), .en (advance), .a (coef_c_mag), .b (ln_cu), .p (p_c)
  );

  // Terms in Q40, truncated toward zero, and their sum.
  logic [48:0]                  b_shift;
  logic [46:0]                  c_shift;
  logic                         t_v, s_v, d_v;
  logic signed [TW-1:0]         t_b, t_c;
  logic [thc_pkg::STATUS_W-1:0] t_s, s_s, d_s;
  logic signed [INV_W-1:0]      s_inv, inv_next;
  logic [NUM2-1:0]              d_num;
  logic [DEN2-1:0]              d_den;

  assign b_shift  = p_b[82:34];
  assign c_shift  = p_c[92:46];
  assign inv_next = INV_W'(coef_a) + INV_W'(t_b) + INV_W'(t_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      lv   <= 1'b0;
      m1_v <= 1'b0;
      m2_v <= 1'b0;
      q1_v <= 1'b0;
      q2_v <= 1'b0;
      r1_v <= 1'b0;
      r2_v <= 1'b0;
      c1_v <= 1'b0;
      c2_v <= 1'b0;
      t_v  <= 1'b0;
      s_v  <= 1'b0;
      d_v  <= 1'b0;
    end else if (advance) begin
      lv   <= sq_v[SQ_N-1];
      m1_v <= lv;
      m2_v <= m1_v;
      q1_v <= m2_v;
      q2_v <= q1_v;
      r1_v <= q2_v;
      r2_v <= r1_v;
      c1_v <= r2_v;
      c2_v <= c1_v;
      t_v  <= c2_v;
      s_v  <= t_v;
      d_v  <= s_v;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      l_neg <= l_two[36];
      l_mag <= l_two[36] ? 36'(-l_two) : l_two[35:0];
      l_st  <= sq_s[SQ_N-1];
      m1_n  <= l_neg;
      m1_s  <= l_st;
      m2_n  <= m1_n;
      m2_s  <= m1_s;
      q1_n  <= m2_n;
      q1_s  <= m2_s;
      q1_l  <= ln_mag;
      q2_n  <= q1_n;
      q2_s  <= q1_s;
      q2_l  <= q1_l;
      r1_n  <= q2_n;
      r1_s  <= q2_s;
      r1_l  <= q2_l;
      r2_n  <= r1_n;
      r2_s  <= r1_s;
      r2_l  <= r1_l;
      c1_n  <= r2_n;
      c1_s  <= r2_s;
      c2_n  <= c1_n;
      c2_s  <= c1_s;
      t_b   <= (c2_n ^ coef_b[thc_pkg::COEF_W-1]) ? -TW'(b_shift) : TW'(b_shift);
      t_c   <= (c2_n ^ coef_cubic[thc_pkg::COEF_W-1]) ? -TW'(c_shift) : TW'(c_shift);
      t_s   <= c2_s;
      s_inv <= inv_next;
      if (t_s == thc_pkg::ST_OK && (inv_next[INV_W-1] || inv_next == '0)) begin
        s_s <= thc_pkg::ST_INV;
      end else begin
        s_s <= t_s;
      end
      d_num <= ONE_N + NUM2'(s_inv[DEN2-1:1]);
      d_den <= s_inv[DEN2-1:0];
      d_s   <= s_s;
    end
  end

  // Rounded reciprocal of the inverse temperature.
  logic [NUM2-1:0]              t_q;
  logic                         f_v;
  logic [thc_pkg::STATUS_W-1:0] f_s;

  thc_div #(.NW(NUM2), .DW(DEN2), .SW(1 + thc_pkg::STATUS_W)) u_div_inv (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .num      (d_num),
    .den      (d_den),
    .side_in  ({d_v, d_s}),
    .quo      (t_q),
    .side_out ({f_v, f_s})
  );

  // Kelvin offset, saturation and output register.
  logic signed [thc_pkg::TEMP_W-1:0] out_temp;
  logic [thc_pkg::STATUS_W-1:0]      out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= f_v;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status <= f_s;
      if (f_s != thc_pkg::ST_OK) begin
        out_temp <= '0;
      end else if (t_q > SAT_LIM) begin
        out_temp <= thc_pkg::TEMP_W'(thc_pkg::TEMP_MAX);
      end else begin
        out_temp <= thc_pkg::TEMP_W'(t_q - KEL_N);
      end
    end
  end

  assign result.valid   = out_valid;
  assign result.temp_q8 = out_temp;
  assign result.status  = out_status;

endmodule

`default_nettype wire

@@ design/thc_mul.sv @@
// ----------------------------------------------------------------------------
// Two-stage unsigned multiplier
// Splits both operands in halves, registers the four partial products and
// registers their sum in the second stage.
// ----------------------------------------------------------------------------
`default_nettype none

module thc_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [AW-1:0]    a,
  input  wire logic [BW-1:0]    b,
  output logic      [AW+BW-1:0] p
);

  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic [AL+BL-1:0] pll;
  logic [AL+BH-1:0] plh;
  logic [AH+BL-1:0] phl;
  logic [AH+BH-1:0] phh;

  // Partial products of the operand halves.
  always_ff @(posedge clk) begin
    if (en) begin
      pll <= a[AL-1:0] * b[BL-1:0];
      plh <= a[AL-1:0] * b[BW-1:BL];
      phl <= a[AW-1:AL] * b[BL-1:0];
      phh <= a[AW-1:AL] * b[BW-1:BL];
    end
  end

  // Weighted sum of the partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      p <= PW'(pll) + (PW'(plh) << BL) + (PW'(phl) << AL) + (PW'(phh) << (AL + BL));
    end
  end

endmodule

`default_nettype wire

@@ design/thc_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage; a sideband word, valid bit included, travels
// with each item.
// ----------------------------------------------------------------------------
`default_nettype none

module thc_div #(
  parameter int NW = 52,
  parameter int DW = 16,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic [SW-1:0] side_in,
  output logic      [NW-1:0] quo,
  output logic      [SW-1:0] side_out
);

  // Stage registers: partial remainder, numerator turning into quotient.
  logic [DW-1:0] rem  [NW];
  logic [NW-1:0] qn   [NW];
  logic [DW-1:0] dv   [NW];
  logic [SW-1:0] side [NW];

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DW-1:0] cur_rem;
    logic [NW-1:0] cur_qn;
    logic [DW-1:0] cur_dv;
    logic [SW-1:0] cur_side;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (i == 0) begin : g_first
      assign cur_rem  = '0;
      assign cur_qn   = num;
      assign cur_dv   = den;
      assign cur_side = side_in;
    end else begin : g_next
      assign cur_rem  = rem[i-1];
      assign cur_qn   = qn[i-1];
      assign cur_dv   = dv[i-1];
      assign cur_side = side[i-1];
    end

    // Bring down the next numerator bit and try a subtraction.
    assign trial = {cur_rem, cur_qn[NW-1]};
    assign diff  = trial - {1'b0, cur_dv};
    assign ge    = (trial >= {1'b0, cur_dv});

    always_ff @(posedge clk) begin
      if (rst) begin
        side[i] <= '0;
      end else if (en) begin
        side[i] <= cur_side;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        qn[i]  <= {cur_qn[NW-2:0], ge};
        dv[i]  <= cur_dv;
      end
    end
  end

  assign quo      = qn[NW-1];
  assign side_out = side[NW-1];

endmodule

`default_nettype wire
